@@ design/mvam_pkg.sv @@
package mvam_pkg;

  // Command codes.
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_DEFINE = 2'd1,
    OP_START  = 2'd2,
    OP_MIX    = 2'd3
  } op_t;

  // Register indexes.
  localparam logic [0:0] REG_MASTER_VOLUME = 1'b0;
  localparam logic [15:0] MASTER_VOLUME_RESET = 16'sd410;

  // Sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_VOICE = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_MUL1  = 7'b0001000,
    ST_MUL2  = 7'b0010000,
    ST_ACCUM = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

endpackage

@@ design/mvam_mul.sv @@
// Serial signed multiplier: AW-bit signed multiplicand against a signed
// multiplier of MW bits, one multiplier bit per cycle (shift and add).
module mvam_mul
  import mvam_pkg::*;
#(
  parameter int AW = 32,
  parameter int MW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic signed [AW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic                 done,
  output logic signed [AW+MW-1:0] p
);
  localparam int CW = $clog2(MW + 1);

  logic signed [AW+MW-1:0] acc;
  logic signed [AW+MW-1:0] mcand;
  logic [MW-1:0] mplier;
  logic [CW-1:0] count;
  logic          busy;

  // One bit of the multiplier per cycle; the top bit carries negative weight.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        count <= '0;
        acc <= '0;
        mcand <= (AW+MW)'(a);
        mplier <= b;
      end else if (busy) begin
        if (mplier[0]) begin
          if (count == CW'(MW - 1)) acc <= acc - mcand;
          else acc <= acc + mcand;
        end
        mcand <= mcand <<< 1;
        mplier <= mplier >> 1;
        count <= count + 1'b1;
        if (count == CW'(MW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign p = acc;
endmodule

@@ design/multi_voice_audio_mixer.sv @@
// Command-driven PCM mixer. A command is taken when start is high and busy is
// low; its one result appears on left/right/voice_given/status for a single
// cycle marked by done, and the receiver cannot stall it. Write, define and
// start commands pass through ST_DONE before done is raised. A mix command
// walks every voice in turn, skipping silent ones; each playing voice is
// loaded, then for each channel its sample is read and passed twice through
// the serial multiplier, which shifts one multiplier bit per cycle (voice
// volume, then master volume).
module multi_voice_audio_mixer
  import mvam_pkg::*;
#(
  parameter int VOICES = 32,
  parameter int SAMPLE_WORDS = 4096,
  parameter int SOUNDS = 8,
  parameter int CHANNELS = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [11:0]        addr,
  input  logic signed [15:0] sample_value,
  input  logic [2:0]         sound,
  input  logic [12:0]        length,
  input  logic signed [15:0] voice_volume,
  input  logic               loop,
  output logic               done,
  output logic signed [15:0] left,
  output logic signed [15:0] right,
  output logic [4:0]         voice_given,
  output logic               status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int VW = $clog2(VOICES) > 0 ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);
  localparam int SW = $clog2(SAMPLE_WORDS);
  localparam int NW = $clog2(SOUNDS) > 0 ? $clog2(SOUNDS) : 1;
  localparam int OW = 14;

  // Configuration register.
  logic signed [15:0] master_volume;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) master_volume <= MASTER_VOLUME_RESET;
    else if (psel && penable && pwrite && paddr[1:1] == 1'(REG_MASTER_VOLUME))
      master_volume <= pwdata[15:0];
  end
  assign prdata = (paddr[1:1] == 1'(REG_MASTER_VOLUME)) ? {{16{master_volume[15]}}, master_volume}
                                                         : 32'd0;

  // Memories.
  logic signed [15:0] sample_mem [SAMPLE_WORDS];
  logic [SW-1:0]      snd_start [SOUNDS];
  logic [12:0]        snd_len   [SOUNDS];
  logic [NW-1:0]      v_sound   [VOICES];
  logic [OW-1:0]      v_offset  [VOICES];
  logic               v_loop    [VOICES];
  logic signed [15:0] v_vol     [VOICES];
  logic [VOICES-1:0]  v_play;
  logic [VW-1:0]      free_stack [VOICES];
  logic [CW-1:0]      free_count;

  state_t state;
  logic [VW-1:0] vidx;
  logic          chan;
  logic [15:0]   sum0, sum1;
  logic [SW-1:0] cur_start;
  logic [12:0]   cur_len;
  logic [OW-1:0] cur_off;
  logic signed [15:0] cur_vol;
  logic signed [15:0] smp;
  logic [SW-1:0] raddr;

  // Serial multiplier shared by both products.
  logic mgo, mdone;
  logic signed [31:0] ma;
  logic signed [15:0] mb;
  logic signed [47:0] mp;
  mvam_mul #(.AW(32), .MW(16)) u_mul (
    .clk(clk), .rst(rst), .go(mgo), .a(ma), .b(mb), .done(mdone), .p(mp)
  );

  assign busy = (state != ST_IDLE);
  assign raddr = cur_start + SW'(cur_off);

  // Sample memory read port, registered.
  always_ff @(posedge clk) begin
    smp <= sample_mem[raddr];
  end

  // Truncation toward zero of a 48-bit product by 2^24, low 16 bits kept.
  logic [15:0] contrib;
  always_comb begin
    contrib = mp[47] ? 16'(((mp + 48'sd16777215) >>> 24)) : 16'(mp >>> 24);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
      mgo <= 1'b0;
      v_play <= '0;
      free_count <= CW'(VOICES);
      for (int i = 0; i < VOICES; i++) free_stack[i] <= VW'(i);
    end else begin
      done <= 1'b0;
      mgo <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            left <= '0; right <= '0; voice_given <= '0; status <= 1'b0;
            case (op_t'(op))
              OP_WRITE: begin
                sample_mem[SW'(addr)] <= sample_value;
                state <= ST_DONE;
              end
              OP_DEFINE: begin
                snd_start[NW'(sound)] <= SW'(addr);
                snd_len[NW'(sound)] <= length;
                state <= ST_DONE;
              end
              OP_START: begin
                if (free_count == '0) begin
                  status <= 1'b1;
                end else begin
                  free_count <= free_count - 1'b1;
                  v_sound[free_stack[VW'(free_count - 1'b1)]] <= NW'(sound);
                  v_offset[free_stack[VW'(free_count - 1'b1)]] <= '0;
                  v_loop[free_stack[VW'(free_count - 1'b1)]] <= loop;
                  v_vol[free_stack[VW'(free_count - 1'b1)]] <= voice_volume;
                  v_play[free_stack[VW'(free_count - 1'b1)]] <= 1'b1;
                  voice_given <= 5'(free_stack[VW'(free_count - 1'b1)]);
                end
                state <= ST_DONE;
              end
              default: begin
                sum0 <= '0; sum1 <= '0;
                vidx <= '0;
                state <= ST_VOICE;
              end
            endcase
          end
        end
        // Load the current voice, or skip it if silent.
        ST_VOICE: begin
          if (v_play[vidx]) begin
            cur_start <= snd_start[v_sound[vidx]];
            cur_len <= snd_len[v_sound[vidx]];
            cur_off <= v_offset[vidx];
            cur_vol <= v_vol[vidx];
            chan <= 1'b0;
            state <= ST_READ;
          end else if (vidx == VW'(VOICES - 1)) begin
            left <= sum0; right <= sum1;
            state <= ST_DONE;
          end else begin
            vidx <= vidx + 1'b1;
          end
        end
        // Address settles; read data lands next cycle.
        ST_READ: begin
          state <= ST_MUL1;
          mgo <= 1'b0;
        end
        ST_MUL1: begin
          if (!mgo && !mdone) begin
            ma <= 32'(smp);
            mb <= cur_vol;
            mgo <= 1'b1;
            state <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          if (mdone && ma == 32'(smp) && mb == cur_vol && !mgo) begin
            ma <= mp[31:0];
            mb <= master_volume;
            mgo <= 1'b1;
            state <= ST_ACCUM;
          end
        end
        // Add the contribution and step the offset.
        ST_ACCUM: begin
          if (mdone && !mgo) begin
            if (!chan) sum0 <= sum0 + contrib;
            else sum1 <= sum1 + contrib;
            cur_off <= cur_off + 1'b1;
            if (CHANNELS == 2 && !chan) begin
              chan <= 1'b1;
              state <= ST_READ;
            end else begin
              if ({1'b0, cur_off + 1'b1} >= {{(OW+1-13){1'b0}}, cur_len}) begin
                v_offset[vidx] <= '0;
                if (!v_loop[vidx]) begin
                  v_play[vidx] <= 1'b0;
                  if (free_count < CW'(VOICES)) begin
                    free_stack[VW'(free_count)] <= vidx;
                    free_count <= free_count + 1'b1;
                  end
                end
              end else begin
                v_offset[vidx] <= cur_off + 1'b1;
              end
              if (vidx == VW'(VOICES - 1)) begin
                state <= ST_DONE;
                if (!chan) left <= sum0 + contrib; else left <= sum0;
                if (chan) right <= sum1 + contrib; else right <= sum1;
              end else begin
                vidx <= vidx + 1'b1;
                state <= ST_VOICE;
              end
            end
          end
        end
        ST_DONE: begin
          done <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^{pwdata[31:16], paddr[0]};
endmodule
